>>> design/pulse_run_serial_receiver_top_assert.svh
// ----------------------------------------------------------------------------
// pulse run serial receiver assertion macros
// clocked assertion helpers, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef PULSE_RUN_SERIAL_RECEIVER_TOP_ASSERT_SVH
`define PULSE_RUN_SERIAL_RECEIVER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define PRSR_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define PRSR_ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");
`else
`define PRSR_ASSERT(lbl, clk, rst_n, prop)
`define PRSR_ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

>>> design/prsr_pkg.sv
// ----------------------------------------------------------------------------
// pulse run serial receiver package
// request payload types, status codes and fixed constants
// ----------------------------------------------------------------------------
package prsr_pkg;

  localparam int unsigned TIME_W     = 32;
  localparam int unsigned PULSE_W    = 12;
  localparam int unsigned HALF_W     = 11;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned CNT_W      = 8;

  localparam logic [PULSE_W-1:0] PULSE_RESET = 12'd2048;
  localparam logic [CNT_W-1:0]   CNT_MAX     = 8'hFF;

  typedef enum logic [2:0] {
    ST_BITS     = 3'd0,
    ST_BYTE     = 3'd1,
    ST_GLITCH   = 3'd2,
    ST_OVERRUN  = 3'd3,
    ST_PARITY   = 3'd4
  } status_t;

  typedef struct packed {
    logic [TIME_W-1:0] edge_time;
    logic              line_level;
  } in_item_t;

  typedef struct packed {
    status_t           status;
    logic [BYTE_W-1:0] data_byte;
    logic [CNT_W-1:0]  overflow_count;
    logic [CNT_W-1:0]  parity_error_count;
  } out_item_t;

  typedef logic [PULSE_W-1:0] pulse_len_t;

endpackage

>>> design/prsr_stream_if.sv
// ----------------------------------------------------------------------------
// pulse run serial receiver stream channel
// valid/ready channel carrying one request payload of type T
// ----------------------------------------------------------------------------
interface prsr_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> design/pulse_run_serial_receiver_top.sv
// ----------------------------------------------------------------------------
// pulse run serial receiver top level
// edge timed single wire receiver with valid/ready channels
// ----------------------------------------------------------------------------
// in_req carries one line edge per request: timestamp in us and new level.
// out_rsp returns exactly one result per edge: status, byte and the two
// saturating error counters after that edge.
// cfg_req writes the bit time in us; write it only while no edge is pending.
// an edge is held in an input register, then updated against the receiver
// state in one pass into the result register that drives out_rsp.
// throughput is one edge per cycle unless out_rsp stalls, set by the single
// pass state update.
// in_req.ready stays high while the input register is empty or moving on,
// so a new edge is taken while a finished result still waits on out_rsp.
// when out_rsp stalls, the result holds and one more edge is buffered,
// then in_req.ready drops until the result is taken.
// reset clears all receiver state and counters, empties both registers and
// sets the bit time to 2048 us.
// cfg_req.ready is always high.
// ----------------------------------------------------------------------------
`include "pulse_run_serial_receiver_top_assert.svh"

module pulse_run_serial_receiver_top
  import prsr_pkg::*;
#(
  parameter int unsigned BIT_TIME_LOG2 = 11,
  parameter int unsigned FRAME_BITS    = 11
) (
  input  logic          clk,
  input  logic          rst_n,
  prsr_stream_if.sink   in_req,
  prsr_stream_if.source out_rsp,
  prsr_stream_if.sink   cfg_req
);

  in_item_t   in_item_r;
  logic       in_valid_r, in_valid_nxt;
  logic       out_valid_r, out_valid_nxt;
  pulse_len_t pulse_len_r;
  logic       advance;
  logic       step;
  logic       in_take;
  out_item_t  result;

  always_comb begin
    advance       = !out_valid_r || out_rsp.ready;
    step          = in_valid_r && advance;
    in_take       = in_req.valid && in_req.ready;
    in_valid_nxt  = in_take ? 1'b1 : (step ? 1'b0 : in_valid_r);
    out_valid_nxt = step ? 1'b1 : (out_rsp.ready ? 1'b0 : out_valid_r);
  end

  assign in_req.ready  = !in_valid_r || advance;
  assign cfg_req.ready = 1'b1;
  assign out_rsp.valid = out_valid_r;
  assign out_rsp.data  = result;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      pulse_len_r <= PULSE_RESET;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_req.valid && cfg_req.ready) begin
        pulse_len_r <= cfg_req.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item_r <= in_req.data;
    end
  end

  prsr_core #(
    .BIT_TIME_LOG2 (BIT_TIME_LOG2),
    .FRAME_BITS    (FRAME_BITS)
  ) u_core (
    .clk              (clk),
    .rst_n            (rst_n),
    .step             (step),
    .item             (in_item_r),
    .bit_pulse_length (pulse_len_r),
    .result           (result)
  );

  `PRSR_ASSERT(a_full_stall, clk, rst_n, in_valid_r && out_valid_r && !out_rsp.ready |-> !in_req.ready)
  `PRSR_ASSERT(a_step_result, clk, rst_n, step |=> out_valid_r)
  `PRSR_ASSERT(a_take_buffered, clk, rst_n, in_take |=> in_valid_r)

endmodule

>>> design/prsr_core.sv
// ----------------------------------------------------------------------------
// pulse run serial receiver core
// receiver state, single pass edge update and registered result
// ----------------------------------------------------------------------------
`include "pulse_run_serial_receiver_top_assert.svh"

module prsr_core
  import prsr_pkg::*;
#(
  parameter int unsigned BIT_TIME_LOG2 = 11,
  parameter int unsigned FRAME_BITS    = 11
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  in_item_t   item,
  input  pulse_len_t bit_pulse_length,
  output out_item_t  result
);

  localparam int unsigned QW = TIME_W - BIT_TIME_LOG2;
  localparam int unsigned RW = QW + 1;
  localparam int unsigned SW = RW + 1;
  localparam int unsigned CW = (BIT_TIME_LOG2 > HALF_W) ? BIT_TIME_LOG2 : HALF_W;
  localparam int unsigned PW = $clog2(FRAME_BITS);
  localparam int unsigned NW = $clog2(FRAME_BITS + 1);

  logic [TIME_W-1:0]     last_time_r, last_time_nxt;
  logic                  last_level_r, last_level_nxt;
  logic [PW-1:0]         bit_pos_r, bit_pos_nxt;
  logic [FRAME_BITS-1:0] frame_r, frame_nxt;
  logic                  parity_r, parity_nxt;
  logic [CNT_W-1:0]      ovf_cnt_r, ovf_cnt_nxt;
  logic [CNT_W-1:0]      par_cnt_r, par_cnt_nxt;
  out_item_t             res_r, res_nxt;

  logic [TIME_W-1:0]     elapsed;
  logic [HALF_W-1:0]     half;
  logic                  glitch;
  logic                  round_up;
  logic [RW-1:0]         run;
  logic                  overrun;
  logic [NW-1:0]         n;
  logic [NW-1:0]         pos_sum;
  logic                  done;
  logic [FRAME_BITS-1:0] base_frame;
  logic                  base_par;
  logic [FRAME_BITS-1:0] shifted;
  logic [FRAME_BITS-1:0] ones;
  logic [FRAME_BITS-1:0] frame_new;
  logic                  par_new;
  logic [FRAME_BITS+9:0] frame_ext;

  always_comb begin
    elapsed    = item.edge_time - last_time_r;
    half       = bit_pulse_length[PULSE_W-1:1];
    glitch     = elapsed < TIME_W'(half);
    round_up   = CW'(elapsed[BIT_TIME_LOG2-1:0]) > CW'(half);
    run        = RW'(elapsed[TIME_W-1:BIT_TIME_LOG2]) + RW'(round_up);
    overrun    = (SW'(run) + SW'(bit_pos_r)) > SW'(FRAME_BITS);
    n          = run[NW-1:0];
    pos_sum    = NW'(bit_pos_r) + n;
    done       = pos_sum >= NW'(FRAME_BITS);
    base_frame = (bit_pos_r == '0) ? '0 : frame_r;
    base_par   = (bit_pos_r == '0) ? 1'b0 : parity_r;
    shifted    = base_frame << n;
    ones       = ~({FRAME_BITS{1'b1}} << n);
    if (!last_level_r) begin
      frame_new = shifted | ones;
      par_new   = base_par ^ n[0];
    end else begin
      frame_new = shifted;
      par_new   = base_par;
    end
    frame_ext = {10'd0, frame_new};

    last_time_nxt  = last_time_r;
    last_level_nxt = last_level_r;
    bit_pos_nxt    = bit_pos_r;
    frame_nxt      = frame_r;
    parity_nxt     = parity_r;
    ovf_cnt_nxt    = ovf_cnt_r;
    par_cnt_nxt    = par_cnt_r;
    res_nxt.status    = ST_GLITCH;
    res_nxt.data_byte = '0;

    if (!glitch) begin
      last_time_nxt  = item.edge_time;
      last_level_nxt = item.line_level;
      if (overrun) begin
        ovf_cnt_nxt    = (ovf_cnt_r == CNT_MAX) ? ovf_cnt_r : ovf_cnt_r + 8'd1;
        bit_pos_nxt    = '0;
        res_nxt.status = ST_OVERRUN;
      end else begin
        frame_nxt      = frame_new;
        parity_nxt     = par_new;
        bit_pos_nxt    = pos_sum[PW-1:0];
        res_nxt.status = ST_BITS;
        if (done) begin
          bit_pos_nxt = '0;
          if (!par_new) begin
            res_nxt.status    = ST_BYTE;
            res_nxt.data_byte = frame_ext[9:2];
          end else begin
            par_cnt_nxt    = (par_cnt_r == CNT_MAX) ? par_cnt_r : par_cnt_r + 8'd1;
            res_nxt.status = ST_PARITY;
          end
        end
      end
    end
    res_nxt.overflow_count     = ovf_cnt_nxt;
    res_nxt.parity_error_count = par_cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_time_r  <= '0;
      last_level_r <= 1'b0;
      bit_pos_r    <= '0;
      frame_r      <= '0;
      parity_r     <= 1'b0;
      ovf_cnt_r    <= '0;
      par_cnt_r    <= '0;
    end else if (step) begin
      last_time_r  <= last_time_nxt;
      last_level_r <= last_level_nxt;
      bit_pos_r    <= bit_pos_nxt;
      frame_r      <= frame_nxt;
      parity_r     <= parity_nxt;
      ovf_cnt_r    <= ovf_cnt_nxt;
      par_cnt_r    <= par_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= res_nxt;
    end
  end

  assign result = res_r;

  `PRSR_ASSERT_NEVER(a_pos_range, clk, rst_n, (PW+1)'(bit_pos_r) >= (PW+1)'(FRAME_BITS))
  `PRSR_ASSERT(a_glitch_hold, clk, rst_n, step && glitch |=> last_time_r == $past(last_time_r) && last_level_r == $past(last_level_r))
  `PRSR_ASSERT(a_cnt_mono, clk, rst_n, step |=> ovf_cnt_r >= $past(ovf_cnt_r) && par_cnt_r >= $past(par_cnt_r))

endmodule

>>> bench/pulse_run_serial_receiver_top_test.sv
// ----------------------------------------------------------------------------
// pulse run serial receiver testbench
// drives timed line edges into the receiver and checks every result against
// a cycle-free model of the frame decoder. well-formed frames with random
// data and jitter make up most of the traffic, mixed with glitches, short
// runs, broken frames and random timestamps. several bit time settings are
// used, and bursts at the end drive both error counters into saturation.
// ----------------------------------------------------------------------------
import prsr_pkg::*;

class receiver_scoreboard #(int unsigned BIT_LOG2 = 11, int unsigned FRAME_LEN = 11);
  pulse_len_t           pulse_len;
  logic [TIME_W-1:0]    edge_stamp;
  logic                 level_now;
  logic [3:0]           bit_pos;
  logic [FRAME_LEN-1:0] frame_reg;
  logic                 parity_odd;
  logic [CNT_W-1:0]     overrun_cnt;
  logic [CNT_W-1:0]     parity_cnt;
  out_item_t            rx_results[$];
  int                   errors;

  function new();
    pulse_len   = PULSE_RESET;
    edge_stamp  = '0;
    level_now   = 1'b0;
    bit_pos     = '0;
    frame_reg   = '0;
    parity_odd  = 1'b0;
    overrun_cnt = '0;
    parity_cnt  = '0;
    errors      = 0;
  endfunction

  function void set_bit_time(pulse_len_t len);
    pulse_len = len;
  endfunction

  function int pending();
    return rx_results.size();
  endfunction

  function void decode_edge(in_item_t e);
    logic [TIME_W-1:0] elapsed;
    logic [HALF_W-1:0] half;
    int unsigned       run;
    out_item_t         r;
    half = pulse_len[PULSE_W-1:1];
    elapsed = e.edge_time - edge_stamp;
    r = '0;
    r.status = ST_BITS;
    if (elapsed < half) begin
      r.status = ST_GLITCH;
    end else begin
      edge_stamp = e.edge_time;
      run = elapsed >> BIT_LOG2;
      if ((elapsed & ((1 << BIT_LOG2) - 1)) > half) run++;
      if (run + bit_pos > FRAME_LEN) begin
        if (overrun_cnt != CNT_MAX) overrun_cnt++;
        bit_pos = '0;
        r.status = ST_OVERRUN;
      end else begin
        if (bit_pos == 0) begin
          frame_reg = '0;
          parity_odd = 1'b0;
        end
        bit_pos = bit_pos + run[3:0];
        frame_reg = frame_reg << run;
        // low line during the run shifts in ones
        if (!level_now) begin
          parity_odd = parity_odd ^ run[0];
          frame_reg = frame_reg | FRAME_LEN'((1 << run) - 1);
        end
        if (bit_pos >= FRAME_LEN) begin
          if (!parity_odd) begin
            r.status = ST_BYTE;
            r.data_byte = frame_reg[BYTE_W+1:2];
          end else begin
            if (parity_cnt != CNT_MAX) parity_cnt++;
            r.status = ST_PARITY;
          end
          bit_pos = '0;
        end
      end
      level_now = e.line_level;
    end
    r.overflow_count = overrun_cnt;
    r.parity_error_count = parity_cnt;
    rx_results.push_back(r);
  endfunction

  task report(string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  task check_result(out_item_t got);
    out_item_t want;
    if (rx_results.size() == 0) begin
      report($sformatf("result with no edge pending, status %0d", got.status));
      return;
    end
    want = rx_results.pop_front();
    if (got.status !== want.status)
      report($sformatf("status got %0d want %0d", got.status, want.status));
    if (got.data_byte !== want.data_byte)
      report($sformatf("data_byte got %02h want %02h", got.data_byte, want.data_byte));
    if (got.overflow_count !== want.overflow_count)
      report($sformatf("overflow_count got %0d want %0d",
                       got.overflow_count, want.overflow_count));
    if (got.parity_error_count !== want.parity_error_count)
      report($sformatf("parity_error_count got %0d want %0d",
                       got.parity_error_count, want.parity_error_count));
  endtask
endclass

module pulse_run_serial_receiver_top_test;
  localparam int unsigned BIT_TIME_LOG2 = 11;
  localparam int unsigned FRAME_BITS    = 11;
  localparam int          BIT_TIME      = 1 << BIT_TIME_LOG2;
  localparam int          CYCLE_LIMIT   = 200000;

  typedef receiver_scoreboard #(.BIT_LOG2(BIT_TIME_LOG2), .FRAME_LEN(FRAME_BITS)) rx_sb_t;

  logic   clk;
  logic   rst_n;
  rx_sb_t sb;
  int     edges_sent;
  int     cycle_cnt;
  bit     no_idle;
  bit     hold_rx;

  prsr_stream_if #(.T(in_item_t))   in_if();
  prsr_stream_if #(.T(out_item_t))  out_if();
  prsr_stream_if #(.T(pulse_len_t)) cfg_if();

  pulse_run_serial_receiver_top #(
    .BIT_TIME_LOG2(BIT_TIME_LOG2),
    .FRAME_BITS   (FRAME_BITS)
  ) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (in_if),
    .out_rsp(out_if),
    .cfg_req(cfg_if)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_if.valid && cfg_if.ready) sb.set_bit_time(cfg_if.data);
      if (in_if.valid && in_if.ready) sb.decode_edge(in_if.data);
      if (out_if.valid && out_if.ready) sb.check_result(out_if.data);
    end
  end

  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_if.ready = !hold_rx && (no_idle || $urandom_range(0, 99) >= 36);
    end
  end

  // long receiver stall so the input side backs up
  initial begin
    hold_rx = 1'b0;
    wait (edges_sent >= 250);
    @(posedge clk);
    hold_rx = 1'b1;
    repeat (300) @(posedge clk);
    hold_rx = 1'b0;
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("FAIL");
    $finish;
  end

  function automatic logic rand_level();
    return 1'($urandom_range(0, 1));
  endfunction

  // timing error that still rounds to the intended run length
  function automatic int run_jitter(int half);
    int lo;
    int hi;
    lo = half - (BIT_TIME - 1);
    if (lo < -300) lo = -300;
    hi = (half > 300) ? 300 : half;
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  task automatic send_edge(input logic [TIME_W-1:0] t, input logic lvl);
    while (!no_idle && $urandom_range(0, 99) < 36) begin
      in_if.valid = 1'b0;
      @(negedge clk);
    end
    in_if.data.edge_time = t;
    in_if.data.line_level = lvl;
    in_if.valid = 1'b1;
    do @(posedge clk); while (!in_if.ready);
    edges_sent++;
    @(negedge clk);
  endtask

  task automatic set_bit_time(input pulse_len_t len);
    in_if.valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_if.data = len;
    cfg_if.valid = 1'b1;
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  // sends one frame as runs, MSB first; cut stops after that many runs
  task automatic send_frame(input logic [FRAME_BITS-1:0] pat, input int cut);
    logic [TIME_W-1:0] t;
    logic              b;
    logic              lvl_next;
    int                i;
    int                len;
    int                runs;
    int                half;
    half = int'(sb.pulse_len >> 1);
    if (sb.bit_pos != 0)
      send_edge(sb.edge_stamp + 12 * BIT_TIME + $urandom_range(0, 500), ~pat[FRAME_BITS-1]);
    else if (sb.level_now == pat[FRAME_BITS-1])
      send_edge(sb.edge_stamp + half, ~pat[FRAME_BITS-1]);
    t = sb.edge_stamp;
    i = FRAME_BITS - 1;
    runs = 0;
    while (i >= 0) begin
      b = pat[i];
      len = 0;
      while (i >= 0 && pat[i] == b) begin
        len++;
        i--;
      end
      lvl_next = (i >= 0) ? ~pat[i] : rand_level();
      if (half > 0 && $urandom_range(0, 99) < 8)
        send_edge(t + $urandom_range(0, half - 1), rand_level());
      t = t + len * BIT_TIME + run_jitter(half);
      send_edge(t, lvl_next);
      runs++;
      if (cut != 0 && runs == cut) return;
    end
  endtask

  task automatic boundary_edges();
    int half;
    half = int'(sb.pulse_len >> 1);
    if (half > 0) send_edge(sb.edge_stamp + half - 1, rand_level());
    send_edge(sb.edge_stamp + half, rand_level());
    send_edge(sb.edge_stamp + BIT_TIME + half, rand_level());
    send_edge(sb.edge_stamp + BIT_TIME + half + 1, rand_level());
  endtask

  task automatic directed_edges();
    send_edge(32'd100, 1'b1);
    send_edge(32'(PULSE_RESET >> 1), 1'b0);
    send_edge(sb.edge_stamp + 11 * BIT_TIME, 1'b1);
    send_edge(sb.edge_stamp + 11 * BIT_TIME, 1'b1);
    send_edge(sb.edge_stamp + 12 * BIT_TIME, 1'b0);
    send_edge(sb.edge_stamp - 1, 1'b1);
    send_edge(32'hFFFF_FFFF, 1'b0);
    send_frame(11'b0_1111_1111_00, 0);
    send_frame(11'b1_0000_0000_10, 0);
    send_frame(11'b0_1010_0101_00, 0);
    send_frame(11'b1_0101_0101_00, 0);
  endtask

  task automatic random_traffic(input int count);
    int                    stop_at;
    int                    pick;
    int                    half;
    logic [FRAME_BITS-1:0] pat;
    stop_at = edges_sent + count;
    while (edges_sent < stop_at) begin
      pick = int'($urandom_range(0, 99));
      half = int'(sb.pulse_len >> 1);
      pat = FRAME_BITS'($urandom);
      if ($urandom_range(0, 1) == 0) pat[FRAME_BITS-1] = ~sb.level_now;
      pat[0] = (^pat[FRAME_BITS-1:1]) ^ (pick >= 55 && pick < 65);
      if (pick < 65)
        send_frame(pat, 0);
      else if (pick < 73)
        send_frame(pat, int'($urandom_range(1, 3)));
      else if (pick < 81 && half > 0)
        send_edge(sb.edge_stamp + $urandom_range(0, half - 1), rand_level());
      else if (pick < 94)
        send_edge(sb.edge_stamp + $urandom_range(0, 13 * BIT_TIME), rand_level());
      else
        send_edge($urandom, rand_level());
    end
  endtask

  initial begin
    sb = new();
    edges_sent = 0;
    no_idle = 1'b0;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.data = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    set_bit_time(PULSE_RESET);
    directed_edges();
    boundary_edges();
    random_traffic(250);

    set_bit_time(12'd4095);
    boundary_edges();
    no_idle = 1'b1;
    random_traffic(150);
    no_idle = 1'b0;

    set_bit_time(12'd2);
    boundary_edges();
    random_traffic(150);

    set_bit_time(12'd1);
    boundary_edges();
    random_traffic(100);

    set_bit_time(pulse_len_t'($urandom_range(2, 4095)));
    boundary_edges();
    random_traffic(200);
    // counter saturation: single-run odd frames, then overlong runs
    repeat (270) send_edge(sb.edge_stamp + 11 * BIT_TIME, 1'b0);
    repeat (270) send_edge(sb.edge_stamp + 12 * BIT_TIME + $urandom_range(0, 3000), rand_level());
    in_if.valid = 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.pending() != 0) sb.report("results still outstanding");
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

>>> filelist.f
+incdir+design
design/prsr_pkg.sv
design/prsr_stream_if.sv
design/prsr_core.sv
design/pulse_run_serial_receiver_top.sv
bench/pulse_run_serial_receiver_top_test.sv
